[src/skd_pkg.sv]
`default_nettype none
package skd_pkg;

    localparam int unsigned DATA_W      = 32;
    localparam int unsigned GAIN_W      = 31;
    localparam int unsigned MARKER_W    = 20;
    localparam int unsigned CFG_IDX_W   = 8;
    localparam int unsigned FRAC_BITS   = 30;
    localparam int unsigned DIV_STEPS   = 31;
    localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [DATA_W-1:0]   ONE_Q30      = 32'h4000_0000;
    localparam logic [63:0]         HALF_Q30     = 64'h0000_0000_2000_0000;
    localparam logic [MARKER_W-1:0] MARKER_MAX   = 20'd655360;
    localparam logic [DATA_W-1:0]   Q_RESET      = 32'd10737;
    localparam logic [DATA_W-1:0]   R_RESET      = 32'd1073742;

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = 8'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRED,
        ST_DIV,
        ST_MUL_X,
        ST_MUL_P,
        ST_FIN
    } t_state;

endpackage
`default_nettype wire

[src/skd_div.sv]
`default_nettype none
// Restoring divider for the gain: quotient = floor(num * 2^30 / den), one
// quotient bit per cycle. Requires num <= den; a zero divisor gives zero.
module skd_div (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic [skd_pkg::DATA_W-1:0]          i_num,
    input  wire logic [skd_pkg::DATA_W:0]            i_den,
    output logic                                     o_done,
    output logic [skd_pkg::GAIN_W-1:0]               o_quot
);
    import skd_pkg::*;

    logic [DATA_W+1:0]    r_rem;
    logic [DATA_W:0]      r_den;
    logic [GAIN_W-1:0]    r_quot;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic                 r_den_zero;

    logic [DATA_W+1:0]    trial;
    logic                 bit_q;
    logic [DATA_W+1:0]    rem_kept;

    always_comb begin
        trial    = r_rem - {1'b0, r_den};
        bit_q    = (r_rem >= {1'b0, r_den});
        rem_kept = bit_q ? trial : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem      <= {2'b00, i_num};
            r_den      <= i_den;
            r_quot     <= '0;
            r_den_zero <= (i_den == '0);
        end else if (r_busy) begin
            r_rem  <= {rem_kept[DATA_W:0], 1'b0};
            r_quot <= {r_quot[GAIN_W-2:0], bit_q};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_den_zero ? '0 : r_quot;

endmodule
`default_nettype wire

[src/skd_mul.sv]
`default_nettype none
// Shared 32 x 32 multiplier with a registered product.
module skd_mul (
    input  wire logic                         i_clk,
    input  wire logic [skd_pkg::DATA_W-1:0]   i_a,
    input  wire logic [skd_pkg::DATA_W-1:0]   i_b,
    output logic [2*skd_pkg::DATA_W-1:0]      o_prod
);
    import skd_pkg::*;

    logic [2*DATA_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= {{DATA_W{1'b0}}, i_a} * {{DATA_W{1'b0}}, i_b};
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

[src/scalar_kalman_drift.sv]
`default_nettype none
// Scalar Kalman filter with a random-walk model, tracking a Q16.16 price.
// Input channel (i_in_valid / o_in_ready): one transaction carries a sample,
// a restart flag and an initial estimate. A restart loads the estimate with
// the initial value and the variance with 1.0 before the step runs.
// Output channel (o_out_valid / i_out_ready): one transaction per input,
// carrying the marker size (ten times the absolute drift, saturated at 10.0,
// Q4.16) and the updated estimate (Q16.16).
// Configuration channel (i_cfg_valid / o_cfg_ready): writes the process noise
// (index 0) or the measurement noise (index 1), both Q2.30; other indexes are
// ignored. Writes are always accepted and belong in idle periods.
// The gain divider produces one quotient bit per cycle; a single shared
// multiplier then forms the estimate correction and the new variance in
// turn. A new input is accepted only in the idle state, after the previous
// one has passed its final step.
// The next input may be accepted while a result still waits; if the receiver
// stalls, the block holds its final step until the output register frees.
// Reset restores the default noise values, a zero estimate and a unit variance.
module scalar_kalman_drift (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [31:0]                         i_sample,
    input  wire logic                                i_restart,
    input  wire logic [31:0]                         i_init_value,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [19:0]                              o_marker_size,
    output logic [31:0]                              o_estimate_out,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [skd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [31:0]                         i_cfg_data
);
    import skd_pkg::*;

    // Filter state and configuration.
    logic [DATA_W-1:0]   r_q;
    logic [DATA_W-1:0]   r_r;
    logic [DATA_W-1:0]   r_estimate;
    logic [DATA_W-1:0]   r_variance;
    logic [DATA_W-1:0]   r_sample;
    logic [DATA_W-1:0]   r_p_pred;
    logic [GAIN_W-1:0]   r_gain;

    // Output register.
    logic                r_out_valid;
    logic [MARKER_W-1:0] r_marker;
    logic [DATA_W-1:0]   r_est_out;

    t_state r_state;
    t_state n_state;

    // Sequencer outputs.
    logic                in_ready;
    logic                div_start;
    logic [DATA_W-1:0]   mul_a;
    logic [DATA_W-1:0]   mul_b;
    logic                out_load;

    // Datapath.
    logic                in_accept;
    logic [DATA_W:0]     p_sum;
    logic [DATA_W-1:0]   p_pred;
    logic [DATA_W:0]     denom;
    logic                div_done;
    logic [GAIN_W-1:0]   div_quot;
    logic [2*DATA_W-1:0] mul_prod;
    logic                z_ge_x;
    logic [DATA_W-1:0]   diff;
    logic [2*DATA_W-1:0] rounded;
    logic [DATA_W-1:0]   mag;
    logic [DATA_W-1:0]   x_new;
    logic [DATA_W-1:0]   one_minus_k;
    logic [DATA_W-1:0]   var_new;
    logic [DATA_W-1:0]   drift;
    logic [MARKER_W-1:0] marker;

    assign in_accept = i_in_valid && in_ready;

    // Predicted variance saturates at the 32-bit maximum; the divisor keeps
    // its carry.
    always_comb begin
        p_sum  = {1'b0, r_variance} + {1'b0, r_q};
        p_pred = p_sum[DATA_W] ? {DATA_W{1'b1}} : p_sum[DATA_W-1:0];
        denom  = {1'b0, p_pred} + {1'b0, r_r};
    end

    // The correction magnitude is rounded to nearest with ties away from
    // zero, which a sign-magnitude form gives directly.
    always_comb begin
        z_ge_x      = (r_sample >= r_estimate);
        diff        = z_ge_x ? (r_sample - r_estimate) : (r_estimate - r_sample);
        rounded     = mul_prod + HALF_Q30;
        mag         = rounded[FRAC_BITS +: DATA_W];
        x_new       = z_ge_x ? (r_estimate + mag) : (r_estimate - mag);
        one_minus_k = ONE_Q30 - {1'b0, r_gain};
        var_new     = rounded[FRAC_BITS +: DATA_W];
    end

    // Marker: ten times the drift, which saturates once the drift reaches 1.0.
    always_comb begin
        drift = (r_estimate >= r_sample) ? (r_estimate - r_sample)
                                         : (r_sample - r_estimate);
        if (drift[DATA_W-1:16] != '0) begin
            marker = MARKER_MAX;
        end else begin
            marker = {1'b0, drift[15:0], 3'b000} + {3'b000, drift[15:0], 1'b0};
        end
    end

    skd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (p_pred),
        .i_den   (denom),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    skd_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_PRED;
                end
            end
            ST_PRED: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_MUL_X;
                end
            end
            ST_MUL_X: begin
                n_state = ST_MUL_P;
            end
            ST_MUL_P: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs. The multiplier operands stay put in the final step
    // so that its product holds while the receiver stalls.
    always_comb begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        out_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                in_ready = 1'b1;
            end
            ST_PRED: begin
                div_start = 1'b1;
            end
            ST_DIV: begin
            end
            ST_MUL_X: begin
                mul_a = diff;
                mul_b = {1'b0, r_gain};
            end
            ST_MUL_P: begin
                mul_a = one_minus_k;
                mul_b = r_p_pred;
            end
            ST_FIN: begin
                mul_a    = one_minus_k;
                mul_b    = r_p_pred;
                out_load = !r_out_valid || i_out_ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_q         <= Q_RESET;
            r_r         <= R_RESET;
            r_estimate  <= '0;
            r_variance  <= ONE_Q30;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_PROCESS_NOISE) begin
                    r_q <= i_cfg_data;
                end else if (i_cfg_index == CFG_MEASURE_NOISE) begin
                    r_r <= i_cfg_data;
                end
            end

            if (in_accept && i_restart) begin
                r_estimate <= i_init_value;
                r_variance <= ONE_Q30;
            end else if (r_state == ST_MUL_P) begin
                r_estimate <= x_new;
            end else if (out_load) begin
                r_variance <= var_new;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_sample <= i_sample;
        end
        if (r_state == ST_PRED) begin
            r_p_pred <= p_pred;
        end
        if (r_state == ST_DIV && div_done) begin
            r_gain <= div_quot;
        end
        if (out_load) begin
            r_marker  <= marker;
            r_est_out <= r_estimate;
        end
    end

    assign o_in_ready     = in_ready;
    assign o_out_valid    = r_out_valid;
    assign o_marker_size  = r_marker;
    assign o_estimate_out = r_est_out;
    assign o_cfg_ready    = 1'b1;

endmodule
`default_nettype wire
